// File: hdl/sio_pkg.sv
// Shared types, register indexes, masks and reset values of the configuration space.
package sio_pkg;

  localparam int unsigned NumDevicesDef = 12;
  localparam int unsigned DeviceRegs    = 256;
  localparam int unsigned GlobalRegs    = 48;

  localparam logic [7:0] KeyEnter   = 8'h87;
  localparam logic [7:0] KeyExit    = 8'haa;
  localparam logic [7:0] DevBankMin = 8'(GlobalRegs);
  localparam logic [7:0] ReadFloat  = 8'hff;

  // global register indexes
  localparam logic [7:0] GlbCtrl   = 8'h00;
  localparam logic [7:0] GlbDevSel = 8'h07;
  localparam logic [7:0] GlbId0    = 8'h20;
  localparam logic [7:0] GlbId1    = 8'h21;
  localparam logic [7:0] Glb22     = 8'h22;
  localparam logic [7:0] Glb23     = 8'h23;
  localparam logic [7:0] Glb24     = 8'h24;
  localparam logic [7:0] Glb25     = 8'h25;
  localparam logic [7:0] Glb26     = 8'h26;
  localparam logic [7:0] Glb28     = 8'h28;
  localparam logic [7:0] Glb29     = 8'h29;
  localparam logic [7:0] Glb2a     = 8'h2a;
  localparam logic [7:0] Glb2b     = 8'h2b;
  localparam logic [7:0] Glb2e     = 8'h2e;
  localparam logic [7:0] Glb2f     = 8'h2f;

  localparam logic [7:0] GlbId0Val = 8'h52;
  localparam logic [7:0] GlbId1Val = 8'h41;

  localparam logic [7:0] Mask23 = 8'h01;
  localparam logic [7:0] Mask24 = 8'hc5;
  localparam logic [7:0] Mask25 = 8'h39;
  localparam logic [7:0] Mask26 = 8'hef;
  localparam logic [7:0] Mask28 = 8'h07;
  localparam logic [7:0] Mask29 = 8'hfc;

  localparam logic [7:0] Rst22 = 8'hff;
  localparam logic [7:0] Rst24 = 8'h80;
  localparam logic [7:0] Rst2a = 8'h7c;
  localparam logic [7:0] Rst2b = 8'hc0;

  // logical device register indexes
  localparam logic [7:0] DevAct  = 8'h30;
  localparam logic [7:0] DevBase = 8'h60;
  localparam logic [7:0] DevBasL = 8'h61;
  localparam logic [7:0] DevIrq  = 8'h70;
  localparam logic [7:0] DevDma  = 8'h74;
  localparam logic [7:0] FdcF0   = 8'hf0;
  localparam logic [7:0] FdcF1   = 8'hf1;
  localparam logic [7:0] FdcF2   = 8'hf2;
  localparam logic [7:0] FdcF4   = 8'hf4;
  localparam logic [7:0] FdcF5   = 8'hf5;

  localparam logic [7:0] MaskF4 = 8'h5b;

  localparam logic [7:0] FdcRstBaseH = 8'h03;
  localparam logic [7:0] FdcRstBaseL = 8'hf0;
  localparam logic [3:0] FdcRstIrq   = 4'h6;
  localparam logic [2:0] FdcRstDma   = 3'h4;
  localparam logic [7:0] FdcRstF0    = 8'h0e;
  localparam logic [7:0] FdcRstF2    = 8'hff;

  localparam logic [7:0] UartDev      = 8'd2;
  localparam logic [7:0] UartRstAct   = 8'h01;
  localparam logic [7:0] UartRstBaseH = 8'h03;
  localparam logic [7:0] UartRstBaseL = 8'hf8;
  localparam logic [7:0] UartRstIrq   = 8'h04;

  typedef struct packed {
    logic       we;
    logic [7:0] idx;
    logic [7:0] data;
  } sio_wr_t;

  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] dev;
    logic [7:0] idx;
    logic [7:0] data;
  } sio_dev_acc_t;

  typedef struct packed {
    logic        enabled;
    logic [15:0] io_base;
    logic [3:0]  irq;
    logic [1:0]  dma_channel;
    logic        dma_valid;
  } sio_fdc_stat_t;

  function automatic logic [7:0] dev_default(input logic [7:0] dev, input logic [7:0] idx);
    logic [7:0] v;
    v = 8'h00;
    if (dev == UartDev) begin
      case (idx)
        DevAct:  v = UartRstAct;
        DevBase: v = UartRstBaseH;
        DevBasL: v = UartRstBaseL;
        DevIrq:  v = UartRstIrq;
        default: v = 8'h00;
      endcase
    end
    return v;
  endfunction

endpackage

// File: hdl/sio_if.sv
// Request and response channel interfaces of the configuration space.
interface sio_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic       port_select;
  logic [7:0] write_data;

  modport source (output valid, command, port_select, write_data, input ready);
  modport sink   (input valid, command, port_select, write_data, output ready);
endinterface

interface sio_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        extended_mode;
  logic [7:0]  selected_device;
  logic        fdc_enabled;
  logic [15:0] fdc_port_base;
  logic [3:0]  fdc_irq;
  logic [1:0]  fdc_dma_channel;
  logic        fdc_dma_valid;

  modport source (output valid, read_data, extended_mode, selected_device, fdc_enabled,
                  fdc_port_base, fdc_irq, fdc_dma_channel, fdc_dma_valid, input ready);
  modport sink   (input valid, read_data, extended_mode, selected_device, fdc_enabled,
                  fdc_port_base, fdc_irq, fdc_dma_channel, fdc_dma_valid, output ready);
endinterface

// File: hdl/sio_glb.sv
// Global register file: masked writable registers and fixed read values.
module sio_glb
  import sio_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sio_wr_t       wr_i,
  input  logic          srst_i,
  input  logic [7:0]    rd_idx_i,
  input  logic [7:0]    dev_sel_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] r22_q, r24_q, r25_q, r26_q, r29_q, r2a_q, r2b_q, r2e_q, r2f_q;
  logic       r23_q;
  logic [2:0] r28_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r22_q <= Rst22;
      r23_q <= 1'b0;
      r24_q <= Rst24;
      r25_q <= 8'h00;
      r26_q <= 8'h00;
      r28_q <= 3'h0;
      r29_q <= 8'h00;
      r2a_q <= Rst2a;
      r2b_q <= Rst2b;
      r2e_q <= 8'h00;
      r2f_q <= 8'h00;
    end else if (srst_i) begin
      r22_q <= Rst22;
      r23_q <= 1'b0;
      r24_q <= Rst24;
      r25_q <= 8'h00;
      r26_q <= 8'h00;
      r28_q <= 3'h0;
      r29_q <= 8'h00;
      r2a_q <= Rst2a;
      r2b_q <= Rst2b;
      r2e_q <= 8'h00;
      r2f_q <= 8'h00;
    end else if (wr_i.we) begin
      case (wr_i.idx)
        Glb22:   r22_q <= wr_i.data;
        Glb23:   r23_q <= wr_i.data[0];
        Glb24:   r24_q <= wr_i.data & Mask24;
        Glb25:   r25_q <= wr_i.data & Mask25;
        Glb26:   r26_q <= wr_i.data & Mask26;
        Glb28:   r28_q <= wr_i.data[2:0];
        Glb29:   r29_q <= wr_i.data & Mask29;
        Glb2a:   r2a_q <= wr_i.data;
        Glb2b:   r2b_q <= wr_i.data;
        Glb2e:   r2e_q <= wr_i.data;
        Glb2f:   r2f_q <= wr_i.data;
        default: ;
      endcase
    end
  end

  // control register always reads back zero: writes to it are not stored
  always_comb begin
    unique case (rd_idx_i)
      GlbDevSel: rdata_o = dev_sel_i;
      GlbId0:    rdata_o = GlbId0Val;
      GlbId1:    rdata_o = GlbId1Val;
      Glb22:     rdata_o = r22_q;
      Glb23:     rdata_o = {7'h00, r23_q} & Mask23;
      Glb24:     rdata_o = r24_q;
      Glb25:     rdata_o = r25_q;
      Glb26:     rdata_o = r26_q;
      Glb28:     rdata_o = {5'h00, r28_q} & Mask28;
      Glb29:     rdata_o = r29_q;
      Glb2a:     rdata_o = r2a_q;
      Glb2b:     rdata_o = r2b_q;
      Glb2e:     rdata_o = r2e_q;
      Glb2f:     rdata_o = r2f_q;
      default:   rdata_o = 8'h00;
    endcase
  end

endmodule

// File: hdl/sio_fdc.sv
// Floppy logical device registers and decode of base, enable, IRQ and DMA.
module sio_fdc
  import sio_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sio_wr_t       wr_i,
  input  logic          srst_i,
  input  logic [7:0]    rd_idx_i,
  output logic [7:0]    rdata_o,
  output sio_fdc_stat_t stat_o
);

  logic       act_q;
  logic [7:0] base_h_q, base_l_q, f0_q, f1_q, f2_q, f4_q, f5_q;
  logic [3:0] irq_q;
  logic [2:0] dma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b1;
      base_h_q <= FdcRstBaseH;
      base_l_q <= FdcRstBaseL;
      irq_q    <= FdcRstIrq;
      dma_q    <= FdcRstDma;
      f0_q     <= FdcRstF0;
      f1_q     <= 8'h00;
      f2_q     <= FdcRstF2;
      f4_q     <= 8'h00;
      f5_q     <= 8'h00;
    end else if (srst_i) begin
      act_q    <= 1'b1;
      base_h_q <= FdcRstBaseH;
      base_l_q <= FdcRstBaseL;
      irq_q    <= FdcRstIrq;
      dma_q    <= FdcRstDma;
      f0_q     <= FdcRstF0;
      f1_q     <= 8'h00;
      f2_q     <= FdcRstF2;
      f4_q     <= 8'h00;
      f5_q     <= 8'h00;
    end else if (wr_i.we) begin
      case (wr_i.idx)
        DevAct:  act_q    <= wr_i.data[0];
        DevBase: base_h_q <= wr_i.data;
        DevBasL: base_l_q <= wr_i.data;
        DevIrq:  irq_q    <= wr_i.data[3:0];
        DevDma:  dma_q    <= wr_i.data[2:0];
        FdcF0:   f0_q     <= wr_i.data;
        FdcF1:   f1_q     <= wr_i.data;
        FdcF2:   f2_q     <= wr_i.data;
        FdcF4:   f4_q     <= wr_i.data & MaskF4;
        FdcF5:   f5_q     <= wr_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rd_idx_i)
      DevAct:  rdata_o = {7'h00, act_q};
      DevBase: rdata_o = base_h_q;
      DevBasL: rdata_o = base_l_q;
      DevIrq:  rdata_o = {4'h0, irq_q};
      DevDma:  rdata_o = {5'h00, dma_q};
      FdcF0:   rdata_o = f0_q;
      FdcF1:   rdata_o = f1_q;
      FdcF2:   rdata_o = f2_q;
      FdcF4:   rdata_o = f4_q;
      FdcF5:   rdata_o = f5_q;
      default: rdata_o = 8'h00;
    endcase
  end

  always_comb begin
    stat_o.io_base     = {base_h_q, base_l_q};
    stat_o.enabled     = act_q && (stat_o.io_base != 16'h0000);
    stat_o.irq         = irq_q;
    stat_o.dma_valid   = !dma_q[2];
    stat_o.dma_channel = dma_q[2] ? 2'b00 : dma_q[1:0];
  end

endmodule

// File: hdl/sio_devmem.sv
// Register banks of logical devices 1 and up, in one memory with a clearing pass.
module sio_devmem
  import sio_pkg::*;
#(
  parameter int unsigned NUM_DEVICES = NumDevicesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  sio_dev_acc_t acc_i,
  input  logic         srst_i,
  output logic [7:0]   rdata_o,
  output logic         busy_o
);

  localparam logic [7:0] LastDev = 8'(NUM_DEVICES - 1);

  if (NUM_DEVICES > 1) begin : g_mem
    localparam int unsigned MemDepth = (NUM_DEVICES - 1) * DeviceRegs;
    localparam int unsigned AddrW    = $clog2(MemDepth);

    logic [7:0]       mem [MemDepth];
    logic [7:0]       rdata_q;
    logic             clr_q;
    logic [7:0]       clr_dev_q, clr_dev_d;
    logic [7:0]       clr_idx_q;
    logic             clr_d;
    logic [AddrW-1:0] acc_addr, clr_addr;
    logic [7:0]       acc_dev_m1, clr_dev_m1;

    assign acc_dev_m1 = acc_i.dev - 8'd1;
    assign clr_dev_m1 = clr_dev_q - 8'd1;
    assign acc_addr   = AddrW'({acc_dev_m1, acc_i.idx});
    assign clr_addr   = AddrW'({clr_dev_m1, clr_idx_q});

    always_comb begin
      clr_d     = clr_q;
      clr_dev_d = clr_dev_q;
      if (clr_idx_q == 8'hff) begin
        if (clr_dev_q == LastDev) begin
          clr_d = 1'b0;
        end else begin
          clr_dev_d = clr_dev_q + 8'd1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        clr_q     <= 1'b1;
        clr_dev_q <= 8'd1;
        clr_idx_q <= 8'h00;
      end else if (srst_i) begin
        clr_q     <= 1'b1;
        clr_dev_q <= 8'd1;
        clr_idx_q <= 8'h00;
      end else if (clr_q) begin
        clr_q     <= clr_d;
        clr_dev_q <= clr_dev_d;
        clr_idx_q <= clr_idx_q + 8'd1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (clr_q) begin
        mem[clr_addr] <= dev_default(clr_dev_q, clr_idx_q);
      end else if (acc_i.we) begin
        mem[acc_addr] <= acc_i.data;
      end
    end

    always_ff @(posedge clk_i) begin
      if (acc_i.re) begin
        rdata_q <= mem[acc_addr];
      end
    end

    assign rdata_o = rdata_q;
    assign busy_o  = clr_q;
  end else begin : g_none
    logic unused_acc;
    assign unused_acc = ^{acc_i, srst_i, clk_i, rst_ni, LastDev};
    assign rdata_o    = {8{unused_acc}} & 8'h00;
    assign busy_o     = 1'b0;
  end

endmodule

// File: hdl/superio_config_register_space.sv
// Top level of the index/data configuration space.
// One bus access is taken per transfer on req_i, and every access gives one result
// on rsp_o in the cycle after it is taken; with rsp_o ready and no clearing pass
// running, a new access is taken every cycle. The result register lets the next
// access in as the current result is taken. Logical devices 1 and up live in one
// memory with a single write port; after reset and after a soft reset (bit 0 of
// global register 0x00 written as one) that memory is swept back to its reset
// values by a clearing pass, during which req_i.ready stays low. The status fields
// on rsp_o reflect the state after the access whose read byte is shown.
module superio_config_register_space
  import sio_pkg::*;
#(
  parameter int unsigned NUM_DEVICES = NumDevicesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sio_req_if.sink    req_i,
  sio_rsp_if.source  rsp_o
);

  localparam logic [7:0] DevCnt = 8'(NUM_DEVICES);

  logic [7:0]    index_q, index_d;
  logic          ext_q, ext_d;
  logic [7:0]    dev_q, dev_d;
  logic          out_valid_q;
  logic [7:0]    rd_q, rd_d;
  logic          rd_mem_q, rd_mem_d;

  logic          acc, is_wr, dp, in_glb, dev_none, dev_fdc;
  logic          srst, busy;
  logic [7:0]    glb_rdata, fdc_rdata, mem_rdata;
  sio_wr_t       glb_wr, fdc_wr;
  sio_dev_acc_t  mem_acc;
  sio_fdc_stat_t fdc_stat;

  assign req_i.ready = !busy && (!out_valid_q || rsp_o.ready);
  assign acc         = req_i.valid && req_i.ready;
  assign is_wr       = req_i.command;
  assign dp          = req_i.port_select;
  assign in_glb      = index_q < DevBankMin;
  assign dev_none    = dev_q >= DevCnt;
  assign dev_fdc     = dev_q == 8'd0;

  always_comb begin
    glb_wr.we   = acc && is_wr && dp && in_glb;
    glb_wr.idx  = index_q;
    glb_wr.data = req_i.write_data;
    fdc_wr.we   = acc && is_wr && dp && !in_glb && dev_fdc;
    fdc_wr.idx  = index_q;
    fdc_wr.data = req_i.write_data;
    mem_acc.we   = acc && is_wr && dp && !in_glb && !dev_fdc && !dev_none;
    mem_acc.re   = acc && !is_wr && dp && !in_glb && !dev_fdc && !dev_none;
    mem_acc.dev  = dev_q;
    mem_acc.idx  = index_q;
    mem_acc.data = req_i.write_data;
  end

  assign srst = glb_wr.we && (index_q == GlbCtrl) && req_i.write_data[0];

  always_comb begin
    index_d = index_q;
    ext_d   = ext_q;
    dev_d   = dev_q;
    if (acc && is_wr && !dp) begin
      index_d = req_i.write_data;
      if (req_i.write_data == KeyEnter) begin
        ext_d = 1'b1;
      end else if (req_i.write_data == KeyExit) begin
        ext_d = 1'b0;
      end
    end
    if (glb_wr.we && (index_q == GlbDevSel)) begin
      dev_d = req_i.write_data;
    end
    if (srst) begin
      ext_d = 1'b0;
      dev_d = 8'h00;
    end
  end

  always_comb begin
    rd_d     = 8'h00;
    rd_mem_d = 1'b0;
    if (!is_wr) begin
      if (!dp) begin
        rd_d = index_q;
      end else if (in_glb) begin
        rd_d = glb_rdata;
      end else if (dev_none) begin
        rd_d = ReadFloat;
      end else if (dev_fdc) begin
        rd_d = fdc_rdata;
      end else begin
        rd_mem_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q     <= 8'h00;
      ext_q       <= 1'b0;
      dev_q       <= 8'h00;
      out_valid_q <= 1'b0;
      rd_mem_q    <= 1'b0;
    end else begin
      index_q <= index_d;
      ext_q   <= ext_d;
      dev_q   <= dev_d;
      if (acc) begin
        out_valid_q <= 1'b1;
        rd_mem_q    <= rd_mem_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q <= rd_d;
    end
  end

  sio_glb u_glb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (glb_wr),
    .srst_i    (srst),
    .rd_idx_i  (index_q),
    .dev_sel_i (dev_q),
    .rdata_o   (glb_rdata)
  );

  sio_fdc u_fdc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (fdc_wr),
    .srst_i   (srst),
    .rd_idx_i (index_q),
    .rdata_o  (fdc_rdata),
    .stat_o   (fdc_stat)
  );

  sio_devmem #(
    .NUM_DEVICES (NUM_DEVICES)
  ) u_devmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (mem_acc),
    .srst_i  (srst),
    .rdata_o (mem_rdata),
    .busy_o  (busy)
  );

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.read_data       = rd_mem_q ? mem_rdata : rd_q;
  assign rsp_o.extended_mode   = ext_q;
  assign rsp_o.selected_device = dev_q;
  assign rsp_o.fdc_enabled     = fdc_stat.enabled;
  assign rsp_o.fdc_port_base   = fdc_stat.io_base;
  assign rsp_o.fdc_irq         = fdc_stat.irq;
  assign rsp_o.fdc_dma_channel = fdc_stat.dma_channel;
  assign rsp_o.fdc_dma_valid   = fdc_stat.dma_valid;

  a_busy_no_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !req_i.ready)
    else $error("access taken during memory clearing pass");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_wr) |=> (rsp_o.valid && rsp_o.read_data == 8'h00))
    else $error("write access returned nonzero read byte");

  a_soft_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srst |=> (!ext_q && dev_q == 8'h00 && busy == (NUM_DEVICES > 1)))
    else $error("soft reset did not restore mode, device select or start clearing");

  a_index_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_wr && !dp) |=> (index_q == $past(req_i.write_data)))
    else $error("index port write not latched");

endmodule
